>>> rtl/sppr_pkg.sv
// Shared types, constants and key priority function for the pad poll reader.
package sppr_pkg;

	localparam int BUTTON_BITS = 16;
	localparam int PAD_BITS    = 16;
	localparam int ELAPSED_W   = 18;
	localparam int DELAY_W     = 8;
	localparam int INDEX_W     = 5;
	localparam int CFG_DATA_W  = 18;
	localparam int CFG_IDX_W   = 2;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam logic [INDEX_W:0] LAST_BIT_COUNT = (INDEX_W+1)'(BUTTON_BITS);
	localparam logic [INDEX_W-1:0] PAD_BITS_IDX = INDEX_W'(PAD_BITS);

	localparam logic [DELAY_W-1:0]   LATCH_WIDTH_RST   = 8'd12;
	localparam logic [DELAY_W-1:0]   HALF_PERIOD_RST   = 8'd6;
	localparam logic [ELAPSED_W-1:0] POLL_INTERVAL_RST = 18'd160000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LATCH_WIDTH   = 2'd0,
		REG_HALF_PERIOD   = 2'd1,
		REG_POLL_INTERVAL = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_LATCH = 4'b0010,
		PH_LOW   = 4'b0100,
		PH_HIGH  = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		KEY_NONE  = 3'd0,
		KEY_A     = 3'd1,
		KEY_START = 3'd2,
		KEY_UP    = 3'd3,
		KEY_DOWN  = 3'd4,
		KEY_LEFT  = 3'd5,
		KEY_RIGHT = 3'd6
	} key_t;

	typedef struct packed {
		logic [DELAY_W-1:0]   latch_width;
		logic [DELAY_W-1:0]   half_period;
		logic [ELAPSED_W-1:0] poll_interval;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic [INDEX_W-1:0]   bit_index;
		logic [DELAY_W-1:0]   delay_count;
		logic [PAD_BITS-1:0]  shift_bits;
		logic [ELAPSED_W-1:0] elapsed;
		logic [PAD_BITS-1:0]  last_buttons;
	} state_t;

	typedef struct packed {
		logic                latch_pin;
		logic                clock_pin;
		logic                busy_res;
		logic                answer_valid;
		key_t                key_code;
		logic [PAD_BITS-1:0] pressed_buttons;
	} result_t;

	function automatic logic [PAD_BITS-1:0] valid_mask();
		logic [PAD_BITS-1:0] m;
		m = '0;
		for (int i = 0; i < PAD_BITS; i++) begin
			if (i < BUTTON_BITS) m[i] = 1'b1;
		end
		return m;
	endfunction

	function automatic key_t key_of(logic [PAD_BITS-1:0] b);
		key_t k;
		if (b[8])      k = KEY_A;
		else if (b[3]) k = KEY_START;
		else if (b[4]) k = KEY_UP;
		else if (b[5]) k = KEY_DOWN;
		else if (b[6]) k = KEY_LEFT;
		else if (b[7]) k = KEY_RIGHT;
		else           k = KEY_NONE;
		return k;
	endfunction

endpackage

>>> rtl/sppr_step.sv
// Next-state and pin/answer logic for one microsecond tick of the poll reader.
module sppr_step (
	input  sppr_pkg::cfg_t    cfg,
	input  sppr_pkg::state_t  cur,
	input  logic              data_pin,
	input  logic              poll_request,
	output sppr_pkg::state_t  nxt,
	output sppr_pkg::result_t res
);
	import sppr_pkg::*;

	logic [DELAY_W-1:0] lw;
	logic [DELAY_W-1:0] hw;
	logic               restart;
	logic [DELAY_W-1:0] dly_inc;
	logic [INDEX_W:0]   bit_next;

	assign lw = (cfg.latch_width == '0) ? DELAY_W'(1) : cfg.latch_width;
	assign hw = (cfg.half_period == '0) ? DELAY_W'(1) : cfg.half_period;

	always_comb begin
		nxt                 = cur;
		res.latch_pin       = 1'b0;
		res.clock_pin       = 1'b1;
		res.busy_res        = 1'b0;
		res.answer_valid    = 1'b0;
		res.key_code        = KEY_NONE;
		restart             = 1'b0;

		if (cur.phase == PH_IDLE && poll_request) begin
			if (cur.elapsed < cfg.poll_interval) begin
				res.answer_valid = 1'b1;
			end else begin
				restart         = 1'b1;
				nxt.phase       = PH_LATCH;
				nxt.delay_count = '0;
				nxt.bit_index   = '0;
				nxt.shift_bits  = '0;
			end
		end

		dly_inc  = nxt.delay_count + DELAY_W'(1);
		bit_next = {1'b0, nxt.bit_index} + (INDEX_W+1)'(1);

		if (nxt.phase != PH_IDLE) begin
			res.busy_res    = 1'b1;
			nxt.delay_count = dly_inc;
			case (nxt.phase)
				PH_LATCH: begin
					res.latch_pin = 1'b1;
					if (dly_inc >= lw) begin
						nxt.delay_count = '0;
						nxt.phase       = PH_LOW;
					end
				end
				PH_LOW: begin
					res.clock_pin = 1'b0;
					if (dly_inc >= hw) begin
						if (nxt.bit_index < PAD_BITS_IDX) begin
							nxt.shift_bits = nxt.shift_bits |
								(PAD_BITS'(data_pin) << nxt.bit_index[$clog2(PAD_BITS)-1:0]);
						end
						nxt.delay_count = '0;
						nxt.phase       = PH_HIGH;
					end
				end
				PH_HIGH: begin
					if (dly_inc >= hw) begin
						nxt.delay_count = '0;
						if (bit_next >= LAST_BIT_COUNT) begin
							nxt.last_buttons = ~nxt.shift_bits & valid_mask();
							res.answer_valid = 1'b1;
							res.key_code     = key_of(~nxt.shift_bits & valid_mask());
							nxt.phase        = PH_IDLE;
							nxt.bit_index    = '0;
						end else begin
							nxt.bit_index = bit_next[INDEX_W-1:0];
							nxt.phase     = PH_LOW;
						end
					end
				end
				default: begin
					nxt.phase = PH_IDLE;
				end
			endcase
		end

		if (restart) begin
			nxt.elapsed = ELAPSED_W'(1);
		end else if (cur.elapsed < ELAPSED_MAX) begin
			nxt.elapsed = cur.elapsed + ELAPSED_W'(1);
		end

		res.pressed_buttons = nxt.last_buttons;
	end

endmodule

>>> rtl/snes_pad_poll_reader_core.sv
// Top level of the SNES pad poll reader: config, state and result registers.
//
//  channel | signals                                        | request moves
//  --------+------------------------------------------------+-------------------------
//  in      | in_valid, in_ready, data_pin, poll_request     | one microsecond tick
//  out     | out_valid, out_ready, latch_pin, clock_pin,    | pins and answer of
//          | busy_res, answer_valid, key_code,              | that tick
//          | pressed_buttons                                |
//  cfg     | cfg_we, cfg_index, cfg_data                    | one register write
//
// One request per cycle while in_ready is high: the tick is applied to the state
// registers and its result is captured in the result register on the accepting edge,
// visible the cycle after. in_ready is high whenever the result register is empty or
// being taken in that cycle. Reset clears the sequencer to idle, the elapsed timer and
// the stored buttons, and loads latch width 12, half period 6 and poll interval 160000.
module snes_pad_poll_reader_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              data_pin,
	input  logic                              poll_request,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              latch_pin,
	output logic                              clock_pin,
	output logic                              busy_res,
	output logic                              answer_valid,
	output logic [2:0]                        key_code,
	output logic [sppr_pkg::PAD_BITS-1:0]     pressed_buttons,
	input  logic                              cfg_we,
	input  logic [sppr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sppr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sppr_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;
	logic    in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	sppr_step u_step (
		.cfg          (cfg_q),
		.cur          (state_q),
		.data_pin     (data_pin),
		.poll_request (poll_request),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.latch_width   <= LATCH_WIDTH_RST;
			cfg_q.half_period   <= HALF_PERIOD_RST;
			cfg_q.poll_interval <= POLL_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LATCH_WIDTH:   cfg_q.latch_width   <= cfg_data[DELAY_W-1:0];
				REG_HALF_PERIOD:   cfg_q.half_period   <= cfg_data[DELAY_W-1:0];
				REG_POLL_INTERVAL: cfg_q.poll_interval <= cfg_data[ELAPSED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= PH_IDLE;
			state_q.bit_index    <= '0;
			state_q.delay_count  <= '0;
			state_q.shift_bits   <= '0;
			state_q.elapsed      <= '0;
			state_q.last_buttons <= '0;
			out_valid_q          <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign latch_pin       = res_q.latch_pin;
	assign clock_pin       = res_q.clock_pin;
	assign busy_res        = res_q.busy_res;
	assign answer_valid    = res_q.answer_valid;
	assign key_code        = res_q.key_code;
	assign pressed_buttons = res_q.pressed_buttons;

endmodule

>>> dv/testbench.sv
// Testbench for snes_pad_poll_reader_core: directed and random tick streams checked against a tick predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sppr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [PAD_BITS-1:0] BUTTON_MASK =
		(BUTTON_BITS >= PAD_BITS) ? '1 : ((PAD_BITS'(1) << BUTTON_BITS) - PAD_BITS'(1));

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  data_pin;
	logic                  poll_request;
	logic                  out_valid;
	logic                  out_ready;
	logic                  latch_pin;
	logic                  clock_pin;
	logic                  busy_res;
	logic                  answer_valid;
	logic [2:0]            key_code;
	logic [PAD_BITS-1:0]   pressed_buttons;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	snes_pad_poll_reader_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_pin(data_pin),
		.poll_request(poll_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.latch_pin(latch_pin),
		.clock_pin(clock_pin),
		.busy_res(busy_res),
		.answer_valid(answer_valid),
		.key_code(key_code),
		.pressed_buttons(pressed_buttons),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state and register copy
	phase_t               m_phase;
	logic [INDEX_W-1:0]   m_bit;
	logic [DELAY_W-1:0]   m_delay;
	logic [PAD_BITS-1:0]  m_shift;
	logic [ELAPSED_W-1:0] m_elapsed;
	logic [PAD_BITS-1:0]  m_last;
	logic [DELAY_W-1:0]   m_latch_width;
	logic [DELAY_W-1:0]   m_half_period;
	logic [ELAPSED_W-1:0] m_poll_interval;

	result_t pad_results_q[$];

	int sender_idle_pct;
	int sink_stall_pct;
	int mismatches;
	int quiet_cycles;
	int ticks_sent;
	int reads_started;
	int early_answers;
	int settings_written;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	function automatic key_t pick_key(logic [PAD_BITS-1:0] b);
		if (b[8]) return KEY_A;
		if (b[3]) return KEY_START;
		if (b[4]) return KEY_UP;
		if (b[5]) return KEY_DOWN;
		if (b[6]) return KEY_LEFT;
		if (b[7]) return KEY_RIGHT;
		return KEY_NONE;
	endfunction

	function automatic void reset_pad_model();
		m_phase = PH_IDLE;
		m_bit = '0;
		m_delay = '0;
		m_shift = '0;
		m_elapsed = '0;
		m_last = '0;
		m_latch_width = 8'd12;
		m_half_period = 8'd6;
		m_poll_interval = 18'd160000;
	endfunction

	function automatic result_t predict_tick(input logic d, input logic r);
		result_t res;
		logic [DELAY_W-1:0] lw;
		logic [DELAY_W-1:0] hw;
		logic restart;
		res.latch_pin = 1'b0;
		res.clock_pin = 1'b1;
		res.busy_res = 1'b0;
		res.answer_valid = 1'b0;
		res.key_code = KEY_NONE;
		lw = (m_latch_width == '0) ? DELAY_W'(1) : m_latch_width;
		hw = (m_half_period == '0) ? DELAY_W'(1) : m_half_period;
		restart = 1'b0;
		if (m_phase == PH_IDLE && r) begin
			if (m_elapsed < m_poll_interval) begin
				res.answer_valid = 1'b1;
				early_answers++;
			end else begin
				restart = 1'b1;
				reads_started++;
				m_phase = PH_LATCH;
				m_delay = '0;
				m_bit = '0;
				m_shift = '0;
			end
		end
		if (m_phase != PH_IDLE) begin
			res.busy_res = 1'b1;
			m_delay = m_delay + DELAY_W'(1);
			case (m_phase)
				PH_LATCH: begin
					res.latch_pin = 1'b1;
					if (m_delay >= lw) begin
						m_delay = '0;
						m_phase = PH_LOW;
					end
				end
				PH_LOW: begin
					res.clock_pin = 1'b0;
					if (m_delay >= hw) begin
						if (m_bit < PAD_BITS) m_shift = m_shift | (PAD_BITS'(d) << m_bit);
						m_delay = '0;
						m_phase = PH_HIGH;
					end
				end
				default: begin
					if (m_delay >= hw) begin
						m_delay = '0;
						if (int'(m_bit) + 1 >= BUTTON_BITS) begin
							m_last = ~m_shift & BUTTON_MASK;
							res.answer_valid = 1'b1;
							res.key_code = pick_key(m_last);
							m_phase = PH_IDLE;
							m_bit = '0;
						end else begin
							m_bit = m_bit + INDEX_W'(1);
							m_phase = PH_LOW;
						end
					end
				end
			endcase
		end
		if (restart) m_elapsed = ELAPSED_W'(1);
		else if (m_elapsed != ELAPSED_MAX) m_elapsed = m_elapsed + ELAPSED_W'(1);
		res.pressed_buttons = m_last;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("ERROR %0t %s: got 'h%0h, want 'h%0h", $time, what, got, want);
	endtask

	always @(negedge clk) begin : check_tick_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pad_results_q.size() == 0) begin
				report_mismatch("result with no tick pending", 1, 0);
			end else begin
				want = pad_results_q.pop_front();
				if (latch_pin !== want.latch_pin)
					report_mismatch("latch_pin", latch_pin, want.latch_pin);
				if (clock_pin !== want.clock_pin)
					report_mismatch("clock_pin", clock_pin, want.clock_pin);
				if (busy_res !== want.busy_res)
					report_mismatch("busy_res", busy_res, want.busy_res);
				if (answer_valid !== want.answer_valid)
					report_mismatch("answer_valid", answer_valid, want.answer_valid);
				if (key_code !== want.key_code)
					report_mismatch("key_code", key_code, want.key_code);
				if (pressed_buttons !== want.pressed_buttons)
					report_mismatch("pressed_buttons", pressed_buttons, want.pressed_buttons);
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
			$display("FAIL snes_pad_poll_reader_core");
			$finish;
		end
	end

	task automatic send_tick(input logic d, input logic r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_pin <= d;
		poll_request <= r;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		pad_results_q.push_back(predict_tick(d, r));
		ticks_sent++;
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pad_results_q.size() != 0);
	endtask

	// request a read, then clock it out with the pad image on every sampled bit
	task automatic run_read(input logic [PAD_BITS-1:0] pad);
		send_tick(1'($urandom), 1'b1);
		while (m_phase != PH_IDLE)
			send_tick((m_phase == PH_LOW) ? ~pad[m_bit[3:0]] : 1'($urandom),
				$urandom_range(9) == 0);
	endtask

	task automatic set_config(input logic [DELAY_W-1:0] lw, input logic [DELAY_W-1:0] hp,
			input logic [ELAPSED_W-1:0] pi);
		while (m_phase != PH_IDLE) send_tick(1'($urandom), 1'($urandom));
		wait_results_drained();
		cfg_we <= 1'b1;
		cfg_index <= REG_LATCH_WIDTH;
		cfg_data <= {(CFG_DATA_W-DELAY_W)'($urandom), lw};
		@(posedge clk);
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= {(CFG_DATA_W-DELAY_W)'($urandom), hp};
		@(posedge clk);
		cfg_index <= REG_POLL_INTERVAL;
		cfg_data <= pi;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		m_latch_width = lw;
		m_half_period = hp;
		m_poll_interval = pi;
		settings_written++;
	endtask

	function automatic logic [PAD_BITS-1:0] random_pad();
		case ($urandom_range(2))
			0: return PAD_BITS'($urandom);
			1: return PAD_BITS'(1) << $urandom_range(PAD_BITS-1);
			default: return PAD_BITS'($urandom & $urandom & $urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		sender_idle_pct = 17;
		sink_stall_pct = 17;
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
	endtask

	task automatic test_key_priority();
		logic [PAD_BITS-1:0] pads[9] = '{16'h0000, 16'hFFFF, 16'h0008, 16'h0010, 16'h0020,
			16'h0040, 16'h0080, 16'h00F0, 16'hFEFF};
		set_config(8'd1, 8'd1, 18'd0);
		foreach (pads[i]) run_read(pads[i]);
	endtask

	task automatic test_interval_boundary();
		set_config(8'd1, 8'd1, 18'd40);
		while (m_elapsed < 18'd40) send_tick(1'($urandom), 1'b0);
		run_read(random_pad());
		while (m_elapsed < 18'd39) send_tick(1'($urandom), 1'b0);
		run_read(random_pad());
		run_read(random_pad());
		run_read(random_pad());
	endtask

	task automatic test_width_extremes();
		set_config(8'd0, 8'd0, 18'd0);
		run_read(random_pad());
		run_read(random_pad());
		set_config(8'd255, 8'd1, 18'd0);
		run_read(random_pad());
	endtask

	task automatic test_long_interval();
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		set_config(8'd12, 8'd6, ELAPSED_MAX);
		repeat (6) send_tick(1'($urandom), 1'b1);
		set_config(8'd12, 8'd6, 18'd0);
		run_read(random_pad());
	endtask

	task automatic test_random_traffic();
		int idle_tab[4] = '{0, 78, 0, 17};
		int stall_tab[4] = '{0, 0, 78, 17};
		int start;
		for (int p = 0; p < 4; p++) begin
			set_config(DELAY_W'($urandom_range(0, 6)), DELAY_W'($urandom_range(0, 3)),
				ELAPSED_W'($urandom_range(0, 300)));
			sender_idle_pct = idle_tab[p];
			sink_stall_pct = stall_tab[p];
			start = ticks_sent;
			while (ticks_sent - start < 220) begin
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5, 6: run_read(random_pad());
					7, 8: begin
						repeat ($urandom_range(1, 20))
							send_tick(1'($urandom), $urandom_range(3) == 0);
					end
					default: wait_results_drained();
				endcase
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_pin = 1'b0;
		poll_request = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		mismatches = 0;
		quiet_cycles = 0;
		ticks_sent = 0;
		reads_started = 0;
		early_answers = 0;
		settings_written = 0;
		reset_pad_model();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_key_priority();
		test_interval_boundary();
		test_width_extremes();
		test_long_interval();
		test_random_traffic();

		in_valid <= 1'b0;
		for (int i = 0; i < QUIET_LIMIT && pad_results_q.size() != 0; i++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pad_results_q.size() != 0)
			report_mismatch("ticks left without a result", pad_results_q.size(), 0);

		$display("run covered %0d ticks: %0d controller reads, %0d early answers",
			ticks_sent, reads_started, early_answers);
		$display("register settings: %0d, mismatches: %0d", settings_written, mismatches);
		if (mismatches == 0) begin
			$display("PASS snes_pad_poll_reader_core");
		end else begin
			$display("FAIL snes_pad_poll_reader_core");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/sppr_pkg.sv
rtl/sppr_step.sv
rtl/snes_pad_poll_reader_core.sv
dv/testbench.sv
